FILE: src/tsi_pkg.sv
// ----------------------------------------------------------------------------
// Thrust-to-signal interpolator package
// Field widths, fixed-point constants and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tsi_pkg;

  // Q1.16 command signal, one integer bit so that 1.0 fits.
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned SIG_W   = FRAC_W + 1;
  localparam int unsigned THR_W   = 32;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned ENTRY_W = SIG_W + THR_W;
  localparam int unsigned PROD_W  = THR_W + SIG_W;

  localparam logic [SIG_W-1:0] ONE_Q  = SIG_W'(1) << FRAC_W;
  localparam logic [SIG_W-1:0] ZERO_Q = '0;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_RANGE     = 3'd1,
    STAT_NOT_READY = 3'd2,
    STAT_ORDER     = 3'd3,
    STAT_VALUE     = 3'd4,
    STAT_NO_SEG    = 3'd5
  } status_e;

endpackage

`default_nettype wire

FILE: src/tsi_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tsi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: src/tsi_div.sv
// ----------------------------------------------------------------------------
// Serial restoring divider
// Produces one quotient bit per cycle; the quotient must fit in SIG_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tsi_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [tsi_pkg::PROD_W-1:0]  num_i,
  input  wire logic [tsi_pkg::THR_W-1:0]   den_i,
  output logic                             done_o,
  output logic      [tsi_pkg::SIG_W-1:0]   quo_o
);
  import tsi_pkg::*;

  localparam int unsigned STEP_W = $clog2(SIG_W + 1);

  logic [THR_W:0]    rem_q;
  logic [SIG_W-1:0]  lo_q;
  logic [SIG_W-1:0]  quo_q;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [THR_W:0]    trial;
  logic              fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem_q[THR_W-1:0], lo_q[SIG_W-1]};
  assign fits  = trial >= {1'b0, den_i};

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == STEP_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_W'(SIG_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath. The high part of the dividend is already below the divisor.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i[PROD_W-1:SIG_W]};
      lo_q  <= num_i[SIG_W-1:0];
    end else if (busy_q) begin
      rem_q <= fits ? (trial - {1'b0, den_i}) : trial;
      lo_q  <= {lo_q[SIG_W-2:0], 1'b0};
      quo_q <= {quo_q[SIG_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

FILE: src/thrust_to_signal_interpolator_top.sv
// ----------------------------------------------------------------------------
// Thrust-to-signal interpolator, top level
// Breakpoint table in RAM with checked loading and inverse interpolation.
// ----------------------------------------------------------------------------
// Each input beat gives exactly one result beat. A load at index 0, or one
// that fails the order check, needs no RAM read; other loads read the
// previous entry from RAM. Queries answered without the table go straight
// to the result. A full query makes one RAM read for the last thrust, a
// scan that reads one entry per cycle through the single RAM read port,
// two multiplies, and a serial divider. The block works on one beat at a
// time; the result register lets the next beat enter while a result waits
// to be taken.
`default_nettype none

module thrust_to_signal_interpolator_top #(
  parameter int unsigned MAX_POINTS = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [tsi_pkg::CNT_W-1:0]   cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        mode_i,
  input  wire logic [tsi_pkg::IDX_W-1:0]   entry_index_i,
  input  wire logic [tsi_pkg::SIG_W-1:0]   entry_signal_i,
  input  wire logic [tsi_pkg::THR_W-1:0]   entry_thrust_i,
  input  wire logic [tsi_pkg::SIG_W-1:0]   desired_thrust_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [tsi_pkg::SIG_W-1:0]   motor_signal_o,
  output logic      [2:0]                  status_o
);
  import tsi_pkg::*;

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_LDCHK, S_QMAX, S_QSCAN, S_QMUL, S_QDIVGO, S_QDIVW, S_EMIT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] point_count_q;
  logic [CW-1:0]    next_idx_q;
  logic             ready_q;
  logic             out_valid_q;
  logic [SIG_W-1:0] out_sig_q;
  status_e          out_st_q;
  logic [SIG_W-1:0] res_sig_q;
  status_e          res_st_q;

  logic [IDX_W-1:0] idx_q;
  logic [SIG_W-1:0] sig_q;
  logic [THR_W-1:0] thr_q;
  logic [SIG_W-1:0] m_q;
  logic [THR_W-1:0] target_q;
  logic [AW-1:0]    i_q;
  logic [SIG_W-1:0] prev_sig_q;
  logic [THR_W-1:0] prev_thr_q;
  logic [THR_W-1:0] off_q;
  logic [THR_W-1:0] dt_q;
  logic [SIG_W-1:0] ds_q;
  logic [PROD_W-1:0] prod_q;

  logic [CW-1:0]      n_eff;
  logic               in_acc;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [AW-1:0]      raddr;
  logic [ENTRY_W-1:0] rdata;
  logic [SIG_W-1:0]   rd_sig;
  logic [THR_W-1:0]   rd_thr;
  logic               div_start;
  logic               div_done;
  logic [SIG_W-1:0]   div_quo;
  logic               last_ok;

  // Effective breakpoint count, clamped to at least 2 and to the table depth.
  always_comb begin
    if (point_count_q < CNT_W'(2)) begin
      n_eff = CW'(2);
    end else if (32'(point_count_q) > MAX_POINTS) begin
      n_eff = CW'(MAX_POINTS);
    end else begin
      n_eff = CW'(point_count_q);
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign rd_sig     = rdata[ENTRY_W-1:THR_W];
  assign rd_thr     = rdata[THR_W-1:0];

  // Last entry of the table must carry a signal of exactly 1.0.
  assign last_ok = (32'(idx_q) != 32'(n_eff) - 1) || (sig_q == ONE_Q);

  // Table write: entry 0 at accept, later entries after the order check.
  always_comb begin
    we    = 1'b0;
    waddr = AW'(idx_q);
    wdata = {sig_q, thr_q};
    if (state_q == S_IDLE && in_acc && !mode_i && entry_index_i == '0 &&
        entry_signal_i == '0 && entry_thrust_i == '0) begin
      we    = 1'b1;
      waddr = '0;
      wdata = '0;
    end else if (state_q == S_LDCHK && !(sig_q > ONE_Q || sig_q <= rd_sig ||
                 thr_q <= rd_thr || !last_ok)) begin
      we = 1'b1;
    end
  end

  // Read address for the next cycle.
  always_comb begin
    raddr = '0;
    case (state_q)
      S_IDLE: begin
        if (!mode_i) begin
          raddr = AW'(32'(entry_index_i) - 1);
        end else begin
          raddr = AW'(32'(n_eff) - 1);
        end
      end
      S_QSCAN: raddr = AW'(32'(i_q) + 1);
      default: raddr = '0;
    endcase
  end

  assign div_start = (state_q == S_QDIVGO);

  tsi_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  tsi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_q),
    .den_i   (dt_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Sequencer, table status and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      point_count_q <= CNT_W'(11);
      next_idx_q    <= '0;
      ready_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        point_count_q <= cfg_wdata_i;
        next_idx_q    <= '0;
        ready_q       <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q   <= S_EMIT;
            res_sig_q <= ZERO_Q;
            res_st_q  <= STAT_OK;
            idx_q     <= entry_index_i;
            sig_q     <= entry_signal_i;
            thr_q     <= entry_thrust_i;
            m_q       <= desired_thrust_i;
            if (!mode_i) begin
              ready_q <= 1'b0;
              if (entry_index_i == '0) begin
                if (entry_signal_i != '0 || entry_thrust_i != '0) begin
                  next_idx_q <= '0;
                  res_st_q   <= STAT_VALUE;
                end else begin
                  next_idx_q <= CW'(1);
                end
              end else if (32'(entry_index_i) != 32'(next_idx_q) ||
                           32'(entry_index_i) >= 32'(n_eff)) begin
                next_idx_q <= '0;
                res_st_q   <= STAT_ORDER;
              end else begin
                state_q <= S_LDCHK;
              end
            end else if (desired_thrust_i > ONE_Q) begin
              res_st_q <= STAT_RANGE;
            end else if (!ready_q) begin
              res_st_q <= STAT_NOT_READY;
            end else if (desired_thrust_i == '0 || desired_thrust_i == ONE_Q) begin
              res_sig_q <= desired_thrust_i;
            end else begin
              state_q <= S_QMAX;
            end
          end
        end
        S_LDCHK: begin
          state_q <= S_EMIT;
          if (!we) begin
            next_idx_q <= '0;
            res_st_q   <= STAT_VALUE;
          end else begin
            next_idx_q <= CW'(32'(idx_q) + 1);
            ready_q    <= (32'(idx_q) + 1 == 32'(n_eff));
          end
        end
        S_QMAX: begin
          // Scale the request by the top thrust of the table.
          prod_q  <= PROD_W'(m_q) * PROD_W'(rd_thr);
          i_q     <= '0;
          state_q <= S_QSCAN;
        end
        S_QSCAN: begin
          if (i_q == '0) begin
            target_q   <= prod_q[FRAC_W+THR_W-1:FRAC_W];
            prev_sig_q <= rd_sig;
            prev_thr_q <= rd_thr;
            i_q        <= AW'(1);
          end else if (target_q <= rd_thr) begin
            off_q   <= (target_q >= prev_thr_q) ? (target_q - prev_thr_q) : '0;
            dt_q    <= rd_thr - prev_thr_q;
            ds_q    <= rd_sig - prev_sig_q;
            state_q <= S_QMUL;
          end else if (32'(i_q) == 32'(n_eff) - 1) begin
            res_st_q <= STAT_NO_SEG;
            state_q  <= S_EMIT;
          end else begin
            prev_sig_q <= rd_sig;
            prev_thr_q <= rd_thr;
            i_q        <= AW'(32'(i_q) + 1);
          end
        end
        S_QMUL: begin
          prod_q  <= PROD_W'(off_q) * PROD_W'(ds_q);
          state_q <= S_QDIVGO;
        end
        S_QDIVGO: begin
          state_q <= S_QDIVW;
        end
        S_QDIVW: begin
          if (div_done) begin
            res_sig_q <= prev_sig_q + div_quo;
            state_q   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_sig_q   <= res_sig_q;
            out_st_q    <= res_st_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign motor_signal_o = out_sig_q;
  assign status_o       = out_st_q;

  // A ready table always has every breakpoint loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> (next_idx_q == n_eff))
    else $error("table ready with incomplete load");

  // Any error result carries a zero signal.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STAT_OK) |-> (motor_signal_o == '0))
    else $error("nonzero signal on error result");

  // A register write drops the table, unless it lands on a load check that completes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !ready_q)
    else $error("table still ready after count write");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Thrust-to-signal interpolator testbench
// Loads breakpoint tables, good and broken, and queries them through the
// valid/ready channels. Every result beat is checked against a local
// prediction of the table state and the interpolation arithmetic.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tsi_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned ITEM_GOAL      = 850;
  localparam int unsigned SETTLE_CYCLES  = 80;
  localparam logic        MODE_LOAD      = 1'b0;
  localparam logic        MODE_QUERY     = 1'b1;

  typedef struct packed {
    logic [SIG_W-1:0] motor_signal;
    status_e          status;
  } answer_t;

  // Block ports; the driven inputs are all known from time zero.
  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic             mode_i = 1'b0;
  logic [IDX_W-1:0] entry_index_i = '0;
  logic [SIG_W-1:0] entry_signal_i = '0;
  logic [THR_W-1:0] entry_thrust_i = '0;
  logic [SIG_W-1:0] desired_thrust_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [SIG_W-1:0] motor_signal_o;
  logic [2:0]       status_o;

  // Predicted table state.
  logic [CNT_W-1:0] count_reg = 6'd11;
  logic [SIG_W-1:0] sig_tab [32];
  logic [THR_W-1:0] thr_tab [32];
  int unsigned      load_next = 0;
  bit               tab_ready = 1'b0;

  answer_t     answer_q[$];
  int unsigned fail_count = 0;
  int unsigned beats_sent = 0;
  int unsigned loads_sent = 0;
  int unsigned queries_sent = 0;
  int unsigned ok_queries = 0;
  int unsigned tables_done = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned idle_cycles = 0;

  thrust_to_signal_interpolator_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .entry_index_i   (entry_index_i),
    .entry_signal_i  (entry_signal_i),
    .entry_thrust_i  (entry_thrust_i),
    .desired_thrust_i(desired_thrust_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .motor_signal_o  (motor_signal_o),
    .status_o        (status_o)
  );

  // Clock.
  always #5 clk_i = ~clk_i;

  // Effective breakpoint count after clamping.
  function automatic int unsigned table_points();
    int unsigned c;
    c = count_reg;
    if (c < 2) c = 2;
    if (c > 32) c = 32;
    return c;
  endfunction

  // Predict the answer to one load beat and update the table.
  function automatic status_e predict_load(int unsigned idx, logic [SIG_W-1:0] s,
                                           logic [THR_W-1:0] t);
    int unsigned n;
    n = table_points();
    tab_ready = 1'b0;
    if (idx == 0) begin
      load_next = 0;
      if (s != 0 || t != 0) return STAT_VALUE;
    end else begin
      if (idx != load_next || idx >= n) begin
        load_next = 0;
        return STAT_ORDER;
      end
      if (s > ONE_Q || s <= sig_tab[idx-1] || t <= thr_tab[idx-1]) begin
        load_next = 0;
        return STAT_VALUE;
      end
      if (idx == n - 1 && s != ONE_Q) begin
        load_next = 0;
        return STAT_VALUE;
      end
    end
    sig_tab[idx] = s;
    thr_tab[idx] = t;
    load_next = idx + 1;
    if (load_next == n) tab_ready = 1'b1;
    return STAT_OK;
  endfunction

  // Predict the interpolated signal for one query beat.
  function automatic answer_t predict_query(logic [SIG_W-1:0] m);
    answer_t a;
    int unsigned n;
    longint unsigned target, t0, dt, ds, off;
    a.motor_signal = '0;
    if (m > ONE_Q) begin
      a.status = STAT_RANGE;
      return a;
    end
    if (!tab_ready) begin
      a.status = STAT_NOT_READY;
      return a;
    end
    a.status = STAT_OK;
    if (m == 0 || m == ONE_Q) begin
      a.motor_signal = m;
      return a;
    end
    n = table_points();
    target = (longint'(m) * longint'(thr_tab[n-1])) >> FRAC_W;
    for (int unsigned i = 1; i < n; i++) begin
      if (target <= thr_tab[i]) begin
        t0  = thr_tab[i-1];
        dt  = thr_tab[i] - t0;
        ds  = sig_tab[i] - sig_tab[i-1];
        off = (target >= t0) ? target - t0 : 0;
        a.motor_signal = SIG_W'(sig_tab[i-1] + (dt != 0 ? (off * ds) / dt : 0));
        return a;
      end
    end
    a.status = STAT_NO_SEG;
    return a;
  endfunction

  // Send one beat, with a random gap first, and record its expected answer.
  task automatic send_beat(logic md, logic [IDX_W-1:0] idx, logic [SIG_W-1:0] s,
                           logic [THR_W-1:0] t, logic [SIG_W-1:0] m);
    int unsigned gap;
    answer_t a;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    mode_i           <= md;
    entry_index_i    <= idx;
    entry_signal_i   <= s;
    entry_thrust_i   <= t;
    desired_thrust_i <= m;
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
    end
    @(posedge clk_i);
    if (md == MODE_LOAD) begin
      a.motor_signal = '0;
      a.status = predict_load(idx, s, t);
      loads_sent++;
    end else begin
      a = predict_query(m);
      queries_sent++;
      if (a.status == STAT_OK) ok_queries++;
    end
    answer_q.push_back(a);
    beats_sent++;
  endtask

  // Load beat with random query content.
  task automatic load_beat(int unsigned idx, longint unsigned s, longint unsigned t);
    send_beat(MODE_LOAD, IDX_W'(idx), SIG_W'(s), THR_W'(t), SIG_W'($urandom));
  endtask

  // Query beat with random load content.
  task automatic query_beat(longint unsigned m);
    send_beat(MODE_QUERY, IDX_W'($urandom), SIG_W'($urandom), $urandom, SIG_W'(m));
  endtask

  // Stop sending and wait until every expected answer has come back.
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
  endtask

  // Write the point count while the block is idle.
  task automatic write_count(logic [CNT_W-1:0] v);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    count_reg = v;
    load_next = 0;
    tab_ready = 1'b0;
  endtask

  // Load a well-formed table of n points; a broken entry may be injected.
  // Broken kinds: 1 signal above one, 2 flat signal, 3 flat or falling thrust,
  // 4 last signal short of one (else zero), 5 skipped index, 6 index past count.
  task automatic load_table(int unsigned n, int unsigned broken_at, int unsigned kind,
                            bit full_scale);
    longint unsigned s, t, ps, pt, hi, step;
    ps = 0;
    pt = 0;
    load_beat(0, 0, 0);
    for (int unsigned i = 1; i < n; i++) begin
      if (i == n - 1) begin
        s = ONE_Q;
      end else begin
        hi = ONE_Q - (n - 1 - i);
        s  = ps + 1 + $urandom_range(0, int'((hi - ps - 1) / (n - 1 - i)));
      end
      step = (64'hFFFF_FFFF - pt) / (n - i);
      if (full_scale && i == n - 1) t = 64'hFFFF_FFFF;
      else if ($urandom_range(3) == 0) t = pt + 1;
      else t = pt + 1 + ({$urandom, $urandom} % step);
      if (i == broken_at) begin
        case (kind)
          1: s = ONE_Q + 1 + $urandom_range(0, 65534);
          2: s = ps;
          3: t = pt - (pt != 0 ? $urandom_range(0, 1) : 0);
          4: if (i == n - 1) s = ONE_Q - 1; else s = 0;
          5: begin
            load_beat(i + 1, s, t);
            continue;
          end
          default: begin
            load_beat(n + $urandom_range(0, 31 - n), s, t);
            continue;
          end
        endcase
      end
      load_beat(i, s, t);
      ps = s;
      pt = t;
    end
    tables_done++;
  endtask

  // Random queries, mostly in range.
  task automatic query_burst(int unsigned k);
    int unsigned r;
    for (int unsigned j = 0; j < k; j++) begin
      r = $urandom_range(99);
      if (r < 5) query_beat(0);
      else if (r < 10) query_beat(ONE_Q);
      else if (r < 17) query_beat($urandom_range(65537, 131071));
      else if (r < 22) query_beat($urandom_range(0, 1) ? 1 : 65535);
      else query_beat($urandom_range(1, 65535));
    end
  endtask

  // Queries before any table exists.
  task automatic test_not_ready();
    query_beat(0);
    query_beat(ONE_Q);
    query_beat(131071);
    query_beat(12345);
  endtask

  // Load order and value checks on a three-point table.
  task automatic test_load_checks();
    write_count(6'd3);
    load_beat(2, ONE_Q, 10);
    load_beat(0, 1, 0);
    load_beat(0, 0, 5);
    load_beat(0, 0, 0);
    load_beat(1, 131071, 100);
    load_beat(0, 0, 0);
    load_beat(1, 100, 0);
    load_table(3, 2, 4, 1'b0);
    load_table(3, 0, 0, 1'b1);
  endtask

  // Queries on a ready table: the fixed points, the edges and out of range.
  task automatic test_table_queries();
    query_beat(0);
    query_beat(ONE_Q);
    query_beat(1);
    query_beat(65535);
    query_beat(65537);
  endtask

  // Count below the minimum, and a write that aborts a ready table.
  task automatic test_count_limits();
    write_count(6'd1);
    load_table(2, 0, 0, 1'b0);
    query_beat(32768);
    write_count(6'd0);
    query_beat(32768);
    load_beat(1, ONE_Q, 7);
  endtask

  // Random tables and queries under one idling setting.
  task automatic test_random(int unsigned snd, int unsigned stl, logic [CNT_W-1:0] first,
                             int unsigned goal);
    int unsigned r, n, kind;
    send_idle_pct = snd;
    stall_pct     = stl;
    r = 0;
    while (beats_sent < goal) begin
      if (r == 0) begin
        write_count(first);
      end else if ($urandom_range(3) == 0) begin
        kind = $urandom_range(9);
        if (kind == 0) write_count(6'($urandom_range(32, 63)));
        else if (kind == 1) write_count(6'($urandom_range(0, 1)));
        else write_count(6'($urandom_range(2, 8)));
      end
      n = table_points();
      if ($urandom_range(4) == 0) begin
        load_table(n, $urandom_range(1, n - 1), $urandom_range(1, 6), 1'($urandom));
      end else begin
        load_table(n, 0, 0, $urandom_range(3) == 0);
      end
      if ($urandom_range(5) == 0) begin
        load_beat($urandom_range(0, 31), $urandom_range(0, 131071), $urandom);
      end
      // Hold the sender until the table answers have all come back.
      if (r == 2) wait_drain();
      query_burst($urandom_range(4, 12));
      r++;
    end
  endtask

  // Receiver stalls.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Result checking against the oldest expected answer.
  always @(negedge clk_i) begin
    answer_t a;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (answer_q.size() == 0) begin
        $error("result beat with no answer expected: signal %0d status %0d",
               motor_signal_o, status_o);
        fail_count++;
      end else begin
        a = answer_q.pop_front();
        if (motor_signal_o !== a.motor_signal) begin
          $error("motor_signal expected %0d actual %0d", a.motor_signal, motor_signal_o);
          fail_count++;
        end
        if (status_o !== a.status) begin
          $error("status expected %0d actual %0d", a.status, status_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && in_ready_o) && !(out_valid_o && out_ready_i)) begin
      idle_cycles++;
    end else begin
      idle_cycles = 0;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[thrust_to_signal_interpolator_top] ERROR");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_not_ready();
    test_load_checks();
    test_table_queries();
    test_count_limits();
    test_random(0, 0, 6'd63, beats_sent + ITEM_GOAL / 4);
    test_random(76, 0, 6'd32, beats_sent + ITEM_GOAL / 4);
    test_random(0, 76, 6'd2, beats_sent + ITEM_GOAL / 4);
    test_random(21, 21, 6'd11, beats_sent + ITEM_GOAL / 4);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Covered %0d beats: %0d loads over %0d tables, %0d queries (%0d answered ok).",
             beats_sent, loads_sent, tables_done, queries_sent, ok_queries);
    $display("Idling phases: none, sender gaps, receiver stalls, and both together.");
    if (fail_count == 0 && answer_q.size() == 0) begin
      $display("[thrust_to_signal_interpolator_top] OK");
    end else begin
      $display("[thrust_to_signal_interpolator_top] ERROR");
    end
    $finish;
  end

endmodule
